@@ hdl/trc_pkg.sv @@
package trc_pkg;

  // field widths
  localparam int TIME_W    = 32;
  localparam int RUN_W     = 31;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int OPT_W     = 4;
  localparam int PCT_W     = 8;
  // quotient bits kept by the divider; anything at or above 2**QUO_W clamps
  localparam int QUO_W     = 7;
  localparam int BIT_W     = 3;
  localparam int NUM_W     = TIME_W + QUO_W;

  // command codes
  typedef enum logic [MODE_W-1:0] {
    MODE_POLL   = 3'd0,
    MODE_START  = 3'd1,
    MODE_STOP   = 3'd2,
    MODE_LOCK   = 3'd3,
    MODE_UNLOCK = 3'd4,
    MODE_STATUS = 3'd5
  } trc_mode_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DUR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REENGAGE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPTIONS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_INV     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_RELAY    = 3'd5;

  // option bit positions
  localparam int OPT_START_STOP      = 0;
  localparam int OPT_SINGLE_START    = 1;
  localparam int OPT_DOUBLE_LOCK     = 2;
  localparam int OPT_UNLOCK_INHIBITS = 3;

  localparam logic [TIME_W-1:0]       LOCK_INHIBIT_MS = 32'd10000;
  localparam logic [QUO_W-1:0]        PCT_FULL        = 7'd100;
  localparam logic signed [PCT_W-1:0] PCT_IDLE        = -8'sd1;

  // main sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG_A,
    ST_TRIG_B,
    ST_TRIG_C,
    ST_UNLOCK,
    ST_TIMEOUT,
    ST_ELAPSE,
    ST_DIVIDE,
    ST_FINISH
  } trc_state_t;

  // divider sequencer
  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_CHK,
    DV_ITER,
    DV_DONE
  } trc_dv_state_t;

  // divider result toward the sequencer
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } trc_div_res_t;

endpackage

@@ hdl/trc_if.sv @@
interface trc_in_if;
  logic                        valid;
  logic                        ready;
  logic [trc_pkg::MODE_W-1:0]  mode;
  logic [trc_pkg::TIME_W-1:0]  now_ms;
  logic                        trigger_pressed;
  logic                        unlock_pressed;
  logic [trc_pkg::RUN_W-1:0]   run_ms;
  logic                        use_default;
  logic                        force_req;

  modport source (
    output valid, mode, now_ms, trigger_pressed, unlock_pressed, run_ms,
           use_default, force_req,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, trigger_pressed, unlock_pressed, run_ms,
           use_default, force_req,
    output ready
  );
endinterface

interface trc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              relay_level;
  logic                              locked_flag;
  logic signed [trc_pkg::PCT_W-1:0]  covered_percent;
  logic                              report_valid;

  modport source (
    output valid, relay_level, locked_flag, covered_percent, report_valid,
    input  ready
  );
  modport sink (
    input  valid, relay_level, locked_flag, covered_percent, report_valid,
    output ready
  );
endinterface

@@ hdl/timed_relay_controller_top.sv @@
// Channel  | Dir | Beat contents
// in_ch    | in  | mode, now_ms, trigger_pressed, unlock_pressed, run_ms, use_default, force_req
// out_ch   | out | relay_level, locked_flag, covered_percent, report_valid
// cfg_*    | in  | write enable, register index, write data (no read-back)
//
// One item at a time: a new command or poll is accepted only once the last
// has passed the per-step sequencer and the 7-step restoring divide unit;
// the divide steps are skipped when the covered fraction clamps early.
// rst_n is synchronous; the relay comes up off, all timers at zero.
// A finished result waits in the output register while the next item is
// taken; the final step stalls only while that register is still full.
module timed_relay_controller_top (
  input  logic                             clk,
  input  logic                             rst_n,
  trc_in_if.sink                           in_ch,
  trc_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [trc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [trc_pkg::TIME_W-1:0]       cfg_wdata
);
  import trc_pkg::*;

  // configuration
  logic [TIME_W-1:0] dflt_r, reeng_ms_r, period_r;
  logic [OPT_W-1:0]  opt_r;
  logic              inv_r;

  // sequencer and captured item
  trc_state_t        state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [TIME_W-1:0] now_r;
  logic              trig_r, unl_r, use_def_r, force_r;
  logic [RUN_W-1:0]  run_r;
  logic              idle_r, idle_nxt;
  logic              report_r, report_nxt;

  // controller state
  logic              relay_r, relay_nxt;
  logic              lock_r, lock_nxt;
  logic [TIME_W-1:0] active_r, active_nxt;
  logic [TIME_W-1:0] end_r, end_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [TIME_W-1:0] reeng_r, reeng_nxt;
  logic [TIME_W-1:0] unl_blk_r, unl_blk_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_relay_r, out_lock_r, out_report_r;
  logic signed [PCT_W-1:0] out_pct_r;

  // shared add/compare unit
  logic [TIME_W-1:0] add_op, sum, cmp_b;
  logic              now_gt, now_ge;
  logic              do_start, do_stop;

  // finish step
  logic               in_fire, out_free, load_out;
  logic               run_idle, pct_pos;
  logic [QUO_W-1:0]   pct_val;
  logic [TIME_W-1:0]  since_last;
  logic [TIME_W-1:0]  elapsed;
  trc_div_res_t       div_res;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign load_out = (state_r == ST_FINISH) && out_free;

  assign sum    = now_r + add_op;
  assign now_gt = now_r > cmp_b;
  assign now_ge = now_r >= cmp_b;

  // covered fraction: elapsed = now - (end - length), modulo 2**32
  assign elapsed = now_r - end_r + active_r;

  trc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == ST_ELAPSE),
    .elapsed (elapsed),
    .den     (active_r),
    .res     (div_res)
  );

  assign run_idle   = (active_r == '0);
  assign pct_val    = (div_res.ovf || div_res.quo > PCT_FULL) ? PCT_FULL : div_res.quo;
  assign pct_pos    = !run_idle && (div_res.ovf || div_res.quo != '0);
  assign since_last = now_r - last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_TRIG_A;
      ST_TRIG_A:  state_nxt = (mode_r == MODE_POLL) ? ST_TRIG_B : ST_ELAPSE;
      ST_TRIG_B:  state_nxt = ST_TRIG_C;
      ST_TRIG_C:  state_nxt = ST_UNLOCK;
      ST_UNLOCK:  state_nxt = ST_TIMEOUT;
      ST_TIMEOUT: state_nxt = ST_ELAPSE;
      ST_ELAPSE:  state_nxt = ST_DIVIDE;
      ST_DIVIDE:  if (div_res.done) state_nxt = ST_FINISH;
      ST_FINISH:  if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // per-step controller actions
  always_comb begin
    add_op      = dflt_r;
    cmp_b       = reeng_r;
    do_start    = 1'b0;
    do_stop     = 1'b0;
    idle_nxt    = idle_r;
    report_nxt  = report_r;
    relay_nxt   = relay_r;
    lock_nxt    = lock_r;
    active_nxt  = active_r;
    end_nxt     = end_r;
    last_nxt    = last_r;
    reeng_nxt   = reeng_r;
    unl_blk_nxt = unl_blk_r;

    case (state_r)
      // command, or the start/stop action of a trigger
      ST_TRIG_A: begin
        idle_nxt   = run_idle;
        report_nxt = 1'b1;
        case (mode_r)
          MODE_POLL: begin
            report_nxt = trig_r;
            if (trig_r && opt_r[OPT_START_STOP]) begin
              if (run_idle) begin
                do_start = now_ge && !lock_r;
              end else begin
                add_op  = reeng_ms_r;
                do_stop = 1'b1;
              end
            end
          end
          MODE_START: begin
            add_op   = use_def_r ? dflt_r : TIME_W'(run_r);
            do_start = now_ge && (!lock_r || force_r);
          end
          MODE_STOP: begin
            add_op  = reeng_ms_r;
            do_stop = 1'b1;
          end
          MODE_LOCK:   lock_nxt = 1'b1;
          MODE_UNLOCK: lock_nxt = 1'b0;
          MODE_STATUS: ;
          default:     report_nxt = 1'b0;
        endcase
      end
      // single start
      ST_TRIG_B: begin
        do_start = trig_r && opt_r[OPT_SINGLE_START] && idle_r && now_ge && !lock_r;
      end
      // double trigger lock, else a plain start
      ST_TRIG_C: begin
        if (trig_r) begin
          if (opt_r[OPT_DOUBLE_LOCK]) begin
            if (idle_r && now_gt) begin
              do_start = !lock_r;
            end else begin
              add_op      = LOCK_INHIBIT_MS;
              lock_nxt    = 1'b1;
              unl_blk_nxt = sum;
            end
          end else begin
            do_start = now_ge && !lock_r;
          end
        end
      end
      // unlock button
      ST_UNLOCK: begin
        cmp_b  = unl_blk_r;
        add_op = reeng_ms_r;
        if (unl_r && now_gt) begin
          lock_nxt   = 1'b0;
          report_nxt = 1'b1;
          if (opt_r[OPT_UNLOCK_INHIBITS]) reeng_nxt = sum;
        end
      end
      // run timeout
      ST_TIMEOUT: begin
        cmp_b  = end_r;
        add_op = reeng_ms_r;
        if (!run_idle && end_r != '0 && now_gt) begin
          do_stop    = 1'b1;
          report_nxt = 1'b1;
        end
      end
      // periodic and end-of-run reports, committed with the result
      ST_FINISH: begin
        if (load_out && mode_r == MODE_POLL) begin
          if (pct_pos && period_r != '0 && since_last > period_r) begin
            report_nxt = 1'b1;
            last_nxt   = now_r;
          end
          if (run_idle && last_r != '0) begin
            report_nxt = 1'b1;
            last_nxt   = '0;
          end
        end
      end
      default: ;
    endcase

    if (do_start) begin
      relay_nxt  = 1'b1;
      active_nxt = add_op;
      end_nxt    = sum;
    end
    if (do_stop) begin
      relay_nxt  = 1'b0;
      end_nxt    = now_r;
      reeng_nxt  = sum;
      active_nxt = '0;
    end
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (load_out)     out_valid_nxt = 1'b1;
  end

  // control and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      relay_r     <= 1'b0;
      lock_r      <= 1'b0;
      active_r    <= '0;
      end_r       <= '0;
      last_r      <= '0;
      reeng_r     <= '0;
      unl_blk_r   <= '0;
      idle_r      <= 1'b1;
      report_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      relay_r     <= relay_nxt;
      lock_r      <= lock_nxt;
      active_r    <= active_nxt;
      end_r       <= end_nxt;
      last_r      <= last_nxt;
      reeng_r     <= reeng_nxt;
      unl_blk_r   <= unl_blk_nxt;
      idle_r      <= idle_nxt;
      report_r    <= report_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r     <= '0;
      reeng_ms_r <= '0;
      period_r   <= '0;
      opt_r      <= '0;
      inv_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEFAULT_DUR:   dflt_r     <= cfg_wdata;
        CFG_REENGAGE:      reeng_ms_r <= cfg_wdata;
        CFG_REPORT_PERIOD: period_r   <= cfg_wdata;
        CFG_OPTIONS:       opt_r      <= cfg_wdata[OPT_W-1:0];
        CFG_RELAY_INV:     inv_r      <= cfg_wdata[0];
        // initial relay level writes are ignored; reset always clears the relay
        CFG_INIT_RELAY:    ;
        default:           ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r    <= in_ch.mode;
      now_r     <= in_ch.now_ms;
      trig_r    <= in_ch.trigger_pressed;
      unl_r     <= in_ch.unlock_pressed;
      run_r     <= in_ch.run_ms;
      use_def_r <= in_ch.use_default;
      force_r   <= in_ch.force_req;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_relay_r  <= relay_r ^ inv_r;
      out_lock_r   <= lock_r;
      out_pct_r    <= run_idle ? PCT_IDLE : PCT_W'(pct_val);
      out_report_r <= report_nxt;
    end
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.relay_level     = out_relay_r;
  assign out_ch.locked_flag     = out_lock_r;
  assign out_ch.covered_percent = out_pct_r;
  assign out_ch.report_valid    = out_report_r;

  // divider finishes only while the sequencer waits for it
  a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DIVIDE)
    else $error("divider done outside divide step");

  // a new result beat is loaded only by the finish step
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result loaded outside finish step");

  // covered percent stays within -1..100
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_pct_r >= PCT_IDLE && out_pct_r <= $signed({1'b0, PCT_FULL})))
    else $error("covered percent out of range");

  // a run timeout stops the run: relay off and active length zero
  a_idle_relay_off: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TIMEOUT && !run_idle && end_r != '0 && now_gt)
      |=> (!relay_r && active_r == '0))
    else $error("timeout did not stop the run");

endmodule

@@ hdl/trc_div.sv @@
module trc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [trc_pkg::TIME_W-1:0]    elapsed,
  input  logic [trc_pkg::TIME_W-1:0]    den,
  output trc_pkg::trc_div_res_t         res
);
  import trc_pkg::*;

  trc_dv_state_t      state_r, state_nxt;
  logic [TIME_W-1:0]  elap_r;
  logic [TIME_W-1:0]  den_r;
  logic [NUM_W-1:0]   num_r;
  logic [TIME_W-1:0]  rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [BIT_W-1:0]   bit_r;
  logic               ovf_r;

  logic [QUO_W-1:0]   num_lo;
  logic [TIME_W:0]    trial;
  logic               trial_ge;
  logic               hi_ge;

  // high part of the numerator against the divisor: quotient >= 2**QUO_W
  assign hi_ge    = num_r[NUM_W-1:QUO_W] >= den_r;
  // one restoring step per cycle
  assign num_lo   = num_r[QUO_W-1:0];
  assign trial    = {rem_r, num_lo[bit_r]};
  assign trial_ge = trial >= {1'b0, den_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DV_IDLE: if (start) state_nxt = DV_MUL;
      DV_MUL:  state_nxt = DV_CHK;
      DV_CHK:  state_nxt = hi_ge ? DV_DONE : DV_ITER;
      DV_ITER: if (bit_r == '0) state_nxt = DV_DONE;
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    res.done = (state_r == DV_DONE);
    res.ovf  = ovf_r;
    res.quo  = quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          elap_r <= elapsed;
          den_r  <= den;
        end
      end
      DV_MUL: begin
        num_r <= NUM_W'(elap_r) * NUM_W'(PCT_FULL);
      end
      DV_CHK: begin
        ovf_r <= hi_ge;
        rem_r <= num_r[NUM_W-1:QUO_W];
        quo_r <= '0;
        bit_r <= BIT_W'(QUO_W - 1);
      end
      DV_ITER: begin
        rem_r <= trial_ge ? TIME_W'(trial - {1'b0, den_r}) : trial[TIME_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], trial_ge};
        bit_r <= bit_r - 1'b1;
      end
      default: ;
    endcase
  end

endmodule
